// ===== rtl/ssev_pkg.sv =====
// ---------------------------------------------------------------------------
// ssev_pkg
// Shared types and constants of the sprite scanline evaluator.
// ---------------------------------------------------------------------------
package ssev_pkg;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 8;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int ROW_W       = 6;
  localparam int ROWS        = 64;
  localparam int MEM_BYTES   = 256;
  localparam int LINE_W      = 9;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int WIDE_IDX_W  = 9;

  localparam int SPRITE_ENTRIES_DEF = 64;
  localparam int MAX_SELECTED_DEF   = 8;

  localparam logic [BYTE_W-1:0] WINDOW_RESET = 8'd8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } ssev_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUM
  } ssev_state_t;

endpackage

// ===== rtl/ssev_ram.sv =====
// ---------------------------------------------------------------------------
// ssev_ram
// Generic single-write, single-read RAM with registered read and read enable.
// ---------------------------------------------------------------------------
module ssev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ssev_cmp.sv =====
// ---------------------------------------------------------------------------
// ssev_cmp
// Window compare unit: |Y - scanline| <= window, with zero Y skipped.
// ---------------------------------------------------------------------------
module ssev_cmp
  import ssev_pkg::*;
(
  input  logic [BYTE_W-1:0] sprite_y,
  input  logic [LINE_W-1:0] scan_line,
  input  logic [BYTE_W-1:0] window,
  output logic              hit
);

  logic [LINE_W-1:0] y_ext;
  logic [LINE_W-1:0] diff;

  always_comb begin
    y_ext = {1'b0, sprite_y};
    diff  = (y_ext >= scan_line) ? (y_ext - scan_line) : (scan_line - y_ext);
    hit   = (sprite_y != '0) && (diff <= {1'b0, window});
  end

endmodule

// ===== rtl/sprite_scanline_evaluator.sv =====
// ---------------------------------------------------------------------------
// sprite_scanline_evaluator
// Sprite attribute memory with a per-scanline sprite selection walk.
//
// Input channel (in_*): in_tuser selects the operation. A write item stores
// one byte of attribute memory and gives no result. An evaluate item walks
// SPRITE_ENTRIES four-byte entries, one entry per cycle through the window
// compare unit while the output does not stall. The walk stops early when
// one more than MAX_SELECTED entries match. in_tready is low while a walk
// is running.
// Result channel (out_*): one item per selected sprite, then a summary item
// with tuser and tlast high carrying count and overflow. Results come from
// an output register; a stalled receiver holds the walk on the entry that
// waits to be sent.
// Configuration: cfg_wr_en writes the match window, reset value 8.
// Reset: rst_n is synchronous, active low. Attribute memory reads as zero
// after reset through per-byte valid flops; no clearing pass is run.
// ---------------------------------------------------------------------------
module sprite_scanline_evaluator
  import ssev_pkg::*;
#(
  parameter int SPRITE_ENTRIES = SPRITE_ENTRIES_DEF,
  parameter int MAX_SELECTED   = MAX_SELECTED_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // oam_address[7:0], oam_data[15:8], scan_line[24:16]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // slot[2:0], sprite_y[10:3], sprite_tile[18:11],
                                  // sprite_attributes[26:19], sprite_x[34:27],
                                  // sprite_count[38:35], overflow[39]
  output logic        out_tuser,  // is_summary
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CNT_W = $clog2(SPRITE_ENTRIES + 1);
  localparam int SEL_W = $clog2(MAX_SELECTED + 1);

  ssev_state_t state_r, state_nxt;

  logic [BYTE_W-1:0]    window_r;
  logic [LINE_W-1:0]    line_r, line_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SEL_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MEM_BYTES-1:0] vld_r;
  logic [LANES-1:0]     vq_r;

  logic                 out_vld_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [BYTE_W-1:0]    out_byte_r [LANES];
  logic                 out_sum_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_ovf_r;

  logic [BYTE_W-1:0]    lane_q [LANES];
  logic [BYTE_W-1:0]    lane_m [LANES];
  logic                 rd_en;
  logic [WIDE_IDX_W-1:0] rd_wide;
  logic [ROW_W-1:0]     rd_row;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [BYTE_W-1:0]    wr_data;
  logic                 cmp_hit;
  logic                 hit, room, more, out_free, stall;
  logic                 load_spr, load_sum;

  assign wr_addr = in_tdata[7:0];
  assign wr_data = in_tdata[15:8];
  assign rd_wide = WIDE_IDX_W'(rd_idx_r);
  assign rd_row  = rd_wide[ROW_W-1:0];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ssev_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en && (wr_addr[LANE_W-1:0] == LANE_W'(l))),
      .waddr(wr_addr[ADDR_W-1:LANE_W]),
      .wdata(wr_data),
      .re   (rd_en),
      .raddr(rd_row),
      .rdata(lane_q[l])
    );
    assign lane_m[l] = vq_r[l] ? lane_q[l] : '0;
  end

  ssev_cmp u_cmp (
    .sprite_y (lane_m[0]),
    .scan_line(line_r),
    .window   (window_r),
    .hit      (cmp_hit)
  );

  assign hit      = chk_vld_r && cmp_hit;
  assign room     = cnt_r < SEL_W'(MAX_SELECTED);
  assign more     = rd_idx_r < CNT_W'(SPRITE_ENTRIES);
  assign out_free = !out_vld_r || out_tready;
  assign stall    = hit && room && !out_free;

  always_comb begin
    state_nxt   = state_r;
    line_nxt    = line_r;
    rd_idx_nxt  = rd_idx_r;
    chk_vld_nxt = chk_vld_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    in_tready   = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    load_spr    = 1'b0;
    load_sum    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (ssev_op_t'(in_tuser) == OP_WRITE) begin
            wr_en = 1'b1;
          end else begin
            line_nxt    = in_tdata[24:16];
            rd_idx_nxt  = '0;
            chk_vld_nxt = 1'b0;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (hit && !room) begin
          ovf_nxt     = 1'b1;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_SUM;
        end else if (!stall) begin
          if (hit) begin
            load_spr = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
          if (more) begin
            rd_en       = 1'b1;
            rd_idx_nxt  = rd_idx_r + 1'b1;
            chk_vld_nxt = 1'b1;
          end else begin
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      window_r  <= WINDOW_RESET;
      chk_vld_r <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      rd_idx_r  <= '0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      rd_idx_r  <= rd_idx_nxt;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (load_spr || load_sum) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
    if (rd_en) begin
      for (int l = 0; l < LANES; l++) begin
        vq_r[l] <= vld_r[{rd_row, LANE_W'(l)}];
      end
    end
    if (load_spr) begin
      out_slot_r <= SLOT_W'(cnt_r);
      for (int l = 0; l < LANES; l++) begin
        out_byte_r[l] <= lane_m[l];
      end
      out_sum_r <= 1'b0;
      out_cnt_r <= '0;
      out_ovf_r <= 1'b0;
    end else if (load_sum) begin
      out_slot_r <= '0;
      for (int l = 0; l < LANES; l++) begin
        out_byte_r[l] <= '0;
      end
      out_sum_r <= 1'b1;
      out_cnt_r <= COUNT_W'(cnt_r);
      out_ovf_r <= ovf_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_ovf_r, out_cnt_r, out_byte_r[3], out_byte_r[2],
                       out_byte_r[1], out_byte_r[0], out_slot_r};
  assign out_tuser  = out_sum_r;
  assign out_tlast  = out_sum_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SEL_W'(MAX_SELECTED))
    else $error("selected count beyond limit");

  a_chk_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> state_r == ST_WALK)
    else $error("entry under check outside walk");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_nxt && !ovf_r |-> !room)
    else $error("overflow flagged before list full");

  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !in_tready && !wr_en)
    else $error("item accepted during walk");

endmodule

// ===== sim/sprite_scanline_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// sprite_scanline_evaluator_tb
// Self-checking testbench for the sprite scanline evaluator. A directed table
// covers empty memory, the byte and scanline extremes, the window edge and
// skipped entries. Random entry writes and scanline evaluations follow under
// several match windows and handshake gap patterns. Every result item is
// compared field by field with an in-bench model of the attribute memory and
// its selection walk.
// ----------------------------------------------------------------------------
module sprite_scanline_evaluator_tb
  import ssev_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRY_BYTES  = 4;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYC   = 80;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [BYTE_W-1:0]  y;
    logic [BYTE_W-1:0]  tile;
    logic [BYTE_W-1:0]  attr;
    logic [BYTE_W-1:0]  x;
    logic               is_summary;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    logic               last;
  } scan_result_t;

  typedef struct {
    ssev_op_t          op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [LINE_W-1:0] line;
    bit                typed_empty;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  logic [BYTE_W-1:0] oam_shadow [MEM_BYTES];
  logic [BYTE_W-1:0] sel_window;
  scan_result_t      scan_results_due [$];
  scan_result_t      seen_res;
  scan_result_t      due_res;
  gap_mode_t         gap_mode = GAP_NONE;
  int                errors = 0;
  int                cycle_cnt = 0;
  int                hold_go = 0;
  int                hold_ack = 0;
  int                hold_left = 0;

  stim_row_t dir_rows [21] = '{
    '{OP_EVAL,  8'h00, 8'h00, 9'd0,   1'b1},
    '{OP_EVAL,  8'h00, 8'h00, 9'd261, 1'b1},
    '{OP_WRITE, 8'h00, 8'hFF, 9'd0,   1'b0},
    '{OP_WRITE, 8'h01, 8'h00, 9'd0,   1'b0},
    '{OP_WRITE, 8'h02, 8'hFF, 9'd0,   1'b0},
    '{OP_WRITE, 8'h03, 8'h00, 9'd0,   1'b0},
    '{OP_WRITE, 8'hFC, 8'h01, 9'd0,   1'b0},
    '{OP_WRITE, 8'hFD, 8'hFF, 9'd0,   1'b0},
    '{OP_WRITE, 8'hFE, 8'h00, 9'd0,   1'b0},
    '{OP_WRITE, 8'hFF, 8'hFF, 9'd0,   1'b0},
    '{OP_WRITE, 8'h05, 8'hAA, 9'd0,   1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd0,   1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd255, 1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd261, 1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd256, 1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd128, 1'b1},
    '{OP_WRITE, 8'h08, 8'h80, 9'd0,   1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd136, 1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd137, 1'b1},
    '{OP_WRITE, 8'h00, 8'h00, 9'd0,   1'b0},
    '{OP_EVAL,  8'h00, 8'h00, 9'd255, 1'b1}
  };

  sprite_scanline_evaluator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic int send_gap_pct();
    return (gap_mode == GAP_SEND) ? 72 : (gap_mode == GAP_BOTH) ? 20 : 0;
  endfunction

  function automatic int recv_gap_pct();
    return (gap_mode == GAP_RECV) ? 72 : (gap_mode == GAP_BOTH) ? 20 : 0;
  endfunction

  function automatic void evaluate_scanline(logic [LINE_W-1:0] line);
    int hits;
    bit over;
    int base;
    int y;
    int diff;
    scan_result_t r;
    hits = 0;
    over = 1'b0;
    for (int e = 0; e < SPRITE_ENTRIES_DEF; e++) begin
      base = (e * ENTRY_BYTES) % MEM_BYTES;
      y = oam_shadow[base];
      if (y == 0) continue;
      diff = (y >= int'(line)) ? y - int'(line) : int'(line) - y;
      if (diff > int'(sel_window)) continue;
      if (hits >= MAX_SELECTED_DEF) begin
        over = 1'b1;
        break;
      end
      r = '0;
      r.slot = hits[SLOT_W-1:0];
      r.y    = oam_shadow[base];
      r.tile = oam_shadow[(base + 1) % MEM_BYTES];
      r.attr = oam_shadow[(base + 2) % MEM_BYTES];
      r.x    = oam_shadow[(base + 3) % MEM_BYTES];
      scan_results_due.push_back(r);
      hits++;
    end
    r = '0;
    r.is_summary = 1'b1;
    r.count = hits[COUNT_W-1:0];
    r.ovf = over;
    r.last = 1'b1;
    scan_results_due.push_back(r);
  endfunction

  task automatic send_item(ssev_op_t op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                           logic [LINE_W-1:0] line, bit typed_empty);
    scan_result_t r;
    while ($urandom_range(99) < send_gap_pct()) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tuser  <= op;
    in_tdata  <= {7'd0, line, data, addr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE) begin
      oam_shadow[addr] = data;
    end else if (typed_empty) begin
      r = '0;
      r.is_summary = 1'b1;
      r.last = 1'b1;
      scan_results_due.push_back(r);
    end else begin
      evaluate_scanline(line);
    end
  endtask

  task automatic wait_results_done(int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_window(logic [BYTE_W-1:0] w);
    @(negedge clk);
    cfg_wr_data <= w;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sel_window = w;
  endtask

  task automatic run_random(int n, int focus);
    int sent;
    int pick;
    int e;
    logic [BYTE_W-1:0] y;
    logic [LINE_W-1:0] line;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        e = $urandom_range(SPRITE_ENTRIES_DEF - 1);
        pick = $urandom_range(99);
        if (pick < 10) y = '0;
        else if (pick < 70) y = BYTE_W'($urandom_range(focus + 12, focus - 12));
        else y = BYTE_W'($urandom_range(255));
        send_item(OP_WRITE, ADDR_W'(e * ENTRY_BYTES), y, '0, 1'b0);
        for (int b = 1; b < ENTRY_BYTES; b++) begin
          send_item(OP_WRITE, ADDR_W'(e * ENTRY_BYTES + b), BYTE_W'($urandom_range(255)),
                    LINE_W'($urandom_range(511)), 1'b0);
        end
        sent += ENTRY_BYTES;
      end
      if (pick >= 60 && pick < 85 || $urandom_range(1) == 1) begin
        if ($urandom_range(99) < 60) line = LINE_W'($urandom_range(focus + 12, focus - 12));
        else line = LINE_W'($urandom_range(261));
        send_item(OP_EVAL, ADDR_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                  line, 1'b0);
        sent++;
      end else if (pick >= 85) begin
        send_item(OP_WRITE, ADDR_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                  LINE_W'($urandom_range(511)), 1'b0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_go != hold_ack) begin
      hold_ack   <= hold_go;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res.slot       = out_tdata[2:0];
      seen_res.y          = out_tdata[10:3];
      seen_res.tile       = out_tdata[18:11];
      seen_res.attr       = out_tdata[26:19];
      seen_res.x          = out_tdata[34:27];
      seen_res.count      = out_tdata[38:35];
      seen_res.ovf        = out_tdata[39];
      seen_res.is_summary = out_tuser;
      seen_res.last       = out_tlast;
      if (scan_results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, seen_res);
      end else begin
        due_res = scan_results_due.pop_front();
        if (seen_res != due_res) begin
          errors++;
          if (seen_res.slot != due_res.slot)
            $display("%0t: slot expected %0d actual %0d", $time, due_res.slot, seen_res.slot);
          if (seen_res.y != due_res.y)
            $display("%0t: sprite_y expected %0h actual %0h", $time, due_res.y, seen_res.y);
          if (seen_res.tile != due_res.tile)
            $display("%0t: sprite_tile expected %0h actual %0h", $time, due_res.tile,
                     seen_res.tile);
          if (seen_res.attr != due_res.attr)
            $display("%0t: sprite_attributes expected %0h actual %0h", $time, due_res.attr,
                     seen_res.attr);
          if (seen_res.x != due_res.x)
            $display("%0t: sprite_x expected %0h actual %0h", $time, due_res.x, seen_res.x);
          if (seen_res.is_summary != due_res.is_summary)
            $display("%0t: is_summary expected %0d actual %0d", $time, due_res.is_summary,
                     seen_res.is_summary);
          if (seen_res.count != due_res.count)
            $display("%0t: sprite_count expected %0d actual %0d", $time, due_res.count,
                     seen_res.count);
          if (seen_res.ovf != due_res.ovf)
            $display("%0t: overflow expected %0d actual %0d", $time, due_res.ovf,
                     seen_res.ovf);
          if (seen_res.last != due_res.last)
            $display("%0t: last expected %0d actual %0d", $time, due_res.last, seen_res.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (oam_shadow[i]) oam_shadow[i] = '0;
    sel_window = WINDOW_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].line,
                dir_rows[i].typed_empty);
    end

    run_random(20, $urandom_range(243, 13));
    hold_go++;
    run_random(20, $urandom_range(243, 13));
    wait_results_done(SETTLE_CYC);

    gap_mode = GAP_SEND;
    write_window(8'h00);
    run_random(40, $urandom_range(243, 13));
    wait_results_done(SETTLE_CYC);

    gap_mode = GAP_RECV;
    write_window(8'hFF);
    run_random(20, $urandom_range(243, 13));
    wait_results_done(0);
    run_random(20, $urandom_range(243, 13));
    wait_results_done(SETTLE_CYC);

    gap_mode = GAP_BOTH;
    write_window(BYTE_W'($urandom_range(254, 1)));
    run_random(45, $urandom_range(243, 13));
    wait_results_done(SETTLE_CYC);

    gap_mode = GAP_NONE;
    write_window(WINDOW_RESET);
    run_random(20, $urandom_range(243, 13));
    hold_go++;
    run_random(25, $urandom_range(243, 13));
    wait_results_done(SETTLE_CYC);

    if (errors == 0 && scan_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
